@@ sv/alal_pkg.sv @@
package alal_pkg;

  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_MANUAL = 2'd2;

  localparam logic [1:0] KIND_APPLY    = 2'd0;
  localparam logic [1:0] KIND_LUX      = 2'd1;
  localparam logic [1:0] KIND_IDLE_ERR = 2'd2;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_RAISE = 2'd2;
  localparam logic [1:0] PH_LOWER = 2'd3;

  localparam logic [1:0] REG_MANUAL_GAIN = 2'd0;
  localparam logic [1:0] REG_MANUAL_TIME = 2'd1;
  localparam logic [1:0] REG_LOW_THR     = 2'd2;
  localparam logic [1:0] REG_HIGH_THR    = 2'd3;

  localparam logic [1:0]  GAIN_DEF = 2'd0;
  localparam logic [1:0]  GAIN_MAX = 2'd3;
  localparam logic [2:0]  TIME_DEF = 3'd2;
  localparam logic [2:0]  TIME_MAX = 3'd5;
  localparam logic [15:0] LOW_THR_DEF  = 16'd100;
  localparam logic [15:0] HIGH_THR_DEF = 16'd10000;

  localparam logic [11:0] RES_DIVISOR = 12'd2500;
  localparam int          RES_HALF    = 1250;

  localparam logic signed [63:0] COEF_A = 64'sd726987541625;
  localparam logic signed [63:0] COEF_B = 64'sd11354714868148443;
  localparam logic signed [63:0] COEF_C = 64'sd93949267567403;
  localparam logic signed [63:0] COEF_D = 64'sd1128489476628362;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_SCALE, ST_MUL, ST_POST, ST_DONE
  } state_e;

  typedef enum logic [1:0] {STEP_A, STEP_B, STEP_C, STEP_D} step_e;

  typedef struct packed {
    logic       upd;
    logic       need_lux;
    logic [1:0] res_kind;
    logic [1:0] res_gain;
    logic [2:0] res_time;
    logic       res_corr;
    logic [1:0] phase;
    logic [1:0] gain;
    logic [2:0] tstep;
    logic       corr;
  } ctl_t;

  function automatic logic [3:0] gain_exp(input logic [1:0] g);
    logic [3:0] e;
    case (g)
      2'd0:    e = 4'd4;
      2'd1:    e = 4'd3;
      2'd2:    e = 4'd1;
      default: e = 4'd0;
    endcase
    return e;
  endfunction

endpackage

@@ sv/ambient_light_autorange_lux_top.sv @@
// Results with kind 0 or 2 skip the arithmetic and pass through the done state to the output
// register; a lux result first runs a bit-serial division by 2500 (numerator width NW =
// 30 + FRACTION_BITS), and a corrected one then runs a shift-add multiplier (BW = 23 + FRACTION_BITS).
// Throughput: one item at a time; the next is taken once the current result is in the
// output register. Reset clears control state, auto state and config to defaults.
module ambient_light_autorange_lux_top #(
  parameter int FRACTION_BITS = alal_pkg::FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  in_cmd_i,
  input  logic [15:0] in_raw_count_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_kind_o,
  output logic [1:0]  out_gain_index_o,
  output logic [2:0]  out_time_index_o,
  output logic [31:0] out_lux_x10_o,
  output logic        out_was_corrected_o
);

  localparam int F   = FRACTION_BITS;
  localparam int NW  = 30 + F;
  localparam int XW  = 19 + F;
  localparam int BW  = XW + 4;
  localparam int PW  = 64 + BW;
  localparam int CW  = $clog2(NW + 1);
  localparam int SH0 = F;
  localparam int SH1 = F + 20;
  localparam int SH2 = F + 10;
  localparam int SH3 = F + 50;

  // configuration and auto state
  logic [1:0]  man_gain_q;
  logic [2:0]  man_time_q;
  logic [15:0] low_thr_q, high_thr_q;
  logic [1:0]  phase_q, gain_q;
  logic [2:0]  tstep_q;
  logic        corr_q;

  alal_pkg::state_e state_q, state_d;
  alal_pkg::step_e  step_q;
  alal_pkg::ctl_t   ctl;

  logic [CW-1:0]  cnt_q;
  logic [NW-1:0]  n_q;
  logic [11:0]    rem_q;
  logic [BW-1:0]  x10_q;
  logic [PW-1:0]  p_q;
  logic [63:0]    a_q;
  logic           neg_q;
  logic           wcorr_q;

  logic [1:0]  res_kind_q, res_gain_q;
  logic [2:0]  res_time_q;
  logic        res_corr_q;
  logic [31:0] res_lux_q;

  logic        out_valid_q;
  logic [1:0]  out_kind_q, out_gain_q;
  logic [2:0]  out_time_q;
  logic [31:0] out_lux_q;
  logic        out_corr_q;

  logic in_xfer, out_free, cnt_last;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign cnt_last = (cnt_q == CW'(1));

  // command decode against the auto state
  always_comb begin
    logic       first_bright;
    logic [1:0] ph_eff;
    logic       c_eff;
    ctl = '0;
    ctl.phase = phase_q;
    ctl.gain  = gain_q;
    ctl.tstep = tstep_q;
    ctl.corr  = corr_q;
    first_bright = (phase_q == alal_pkg::PH_FIRST) && (in_raw_count_i > low_thr_q);
    ph_eff = first_bright ? alal_pkg::PH_LOWER : phase_q;
    c_eff  = first_bright ? 1'b1 : corr_q;
    case (in_cmd_i)
      alal_pkg::CMD_START: begin
        ctl.upd      = 1'b1;
        ctl.phase    = alal_pkg::PH_FIRST;
        ctl.gain     = alal_pkg::GAIN_DEF;
        ctl.tstep    = alal_pkg::TIME_DEF;
        ctl.corr     = 1'b0;
        ctl.res_kind = alal_pkg::KIND_APPLY;
        ctl.res_gain = alal_pkg::GAIN_DEF;
        ctl.res_time = alal_pkg::TIME_DEF;
      end
      alal_pkg::CMD_MANUAL: begin
        ctl.upd      = 1'b1;
        ctl.need_lux = 1'b1;
        ctl.res_kind = alal_pkg::KIND_LUX;
        ctl.res_gain = man_gain_q;
        ctl.res_time = (man_time_q > alal_pkg::TIME_MAX) ? alal_pkg::TIME_DEF : man_time_q;
        ctl.res_corr = 1'b1;
      end
      alal_pkg::CMD_SAMPLE: begin
        ctl.upd = 1'b1;
        if (phase_q == alal_pkg::PH_IDLE) begin
          ctl.res_kind = alal_pkg::KIND_IDLE_ERR;
          ctl.res_gain = gain_q;
          ctl.res_time = tstep_q;
        end else begin
          ctl.corr = c_eff;
          ctl.res_kind = alal_pkg::KIND_APPLY;
          if (ph_eff == alal_pkg::PH_LOWER && in_raw_count_i > high_thr_q
              && tstep_q != 3'd0) begin
            ctl.phase    = alal_pkg::PH_LOWER;
            ctl.tstep    = tstep_q - 3'd1;
            ctl.res_gain = gain_q;
            ctl.res_time = tstep_q - 3'd1;
          end else if (ph_eff != alal_pkg::PH_LOWER && in_raw_count_i <= low_thr_q
                       && !(gain_q == alal_pkg::GAIN_MAX && tstep_q == alal_pkg::TIME_MAX)) begin
            ctl.phase = alal_pkg::PH_RAISE;
            if (gain_q < alal_pkg::GAIN_MAX) begin
              ctl.gain = gain_q + 2'd1;
            end else begin
              ctl.tstep = tstep_q + 3'd1;
            end
            ctl.res_gain = ctl.gain;
            ctl.res_time = ctl.tstep;
          end else begin
            ctl.phase    = alal_pkg::PH_IDLE;
            ctl.need_lux = 1'b1;
            ctl.res_kind = alal_pkg::KIND_LUX;
            ctl.res_gain = gain_q;
            ctl.res_time = tstep_q;
            ctl.res_corr = c_eff;
          end
        end
      end
      default: ;
    endcase
  end

  // numerator 9 * raw * 2^(s + F) + 1250
  logic [19:0]   nine_raw;
  logic [3:0]    sexp;
  logic [NW-1:0] num;
  assign nine_raw = {1'b0, in_raw_count_i, 3'b000} + {4'b0000, in_raw_count_i};
  assign sexp = alal_pkg::gain_exp(ctl.res_gain) + 4'd5 - {1'b0, ctl.res_time};
  assign num  = (NW'(nine_raw) << (6'(sexp) + 6'(F))) + NW'(alal_pkg::RES_HALF);

  // restoring division step by 2500
  logic [12:0] dtry;
  logic        dqb;
  logic [11:0] rem_d;
  assign dtry  = {rem_q, n_q[NW-1]};
  assign dqb   = dtry >= {1'b0, alal_pkg::RES_DIVISOR};
  assign rem_d = dqb ? 12'(dtry - {1'b0, alal_pkg::RES_DIVISOR}) : dtry[11:0];

  logic [XW-1:0] xq;
  logic [BW-1:0] x10;
  logic [BW:0]   ux;
  assign xq  = n_q[XW-1:0];
  assign x10 = {xq, 3'b000} + {2'b00, xq, 1'b0};
  assign ux  = ({1'b0, x10} + ((BW+1)'(1) << (F - 1))) >> F;

  // the quotient stays in n_q while the multiplier runs
  logic [XW-1:0] xq_hold;
  assign xq_hold = xq;

  // shift-add multiplier step
  logic [64:0] msum;
  assign msum = {1'b0, p_q[PW-1:BW]} + (p_q[0] ? {1'b0, a_q} : 65'd0);

  // rounding, clamping and coefficient add after each product
  logic [PW-1:0]        pq;
  logic                 rnd;
  logic [62:0]          rmag;
  logic signed [63:0]   sr, hn;
  logic [63:0]          hmag;
  logic [32:0]          v33;
  logic [31:0]          luxf;
  logic                 post_done;
  always_comb begin
    case (step_q)
      alal_pkg::STEP_A: begin pq = p_q >> SH0; rnd = p_q[SH0-1]; end
      alal_pkg::STEP_B: begin pq = p_q >> SH1; rnd = p_q[SH1-1]; end
      alal_pkg::STEP_C: begin pq = p_q >> SH2; rnd = p_q[SH2-1]; end
      default:          begin pq = p_q >> SH3; rnd = p_q[SH3-1]; end
    endcase
    rmag = (|pq[PW-1:62]) ? (63'd1 << 62) : ({1'b0, pq[61:0]} + 63'(rnd));
    sr   = neg_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    case (step_q)
      alal_pkg::STEP_A: hn = sr - alal_pkg::COEF_B;
      alal_pkg::STEP_B: hn = sr + alal_pkg::COEF_C;
      default:          hn = sr + alal_pkg::COEF_D;
    endcase
    hmag = hn[63] ? 64'(-hn) : 64'(hn);
    v33  = {1'b0, pq[31:0]} + 33'(rnd);
    luxf = ((|pq[PW-1:32]) || v33[32]) ? 32'hFFFF_FFFF : v33[31:0];
    post_done = (step_q == alal_pkg::STEP_D) ||
                (step_q == alal_pkg::STEP_C && (hn[63] || hn == 64'sd0));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      alal_pkg::ST_IDLE: begin
        if (in_xfer && ctl.upd) begin
          state_d = ctl.need_lux ? alal_pkg::ST_DIV : alal_pkg::ST_DONE;
        end
      end
      alal_pkg::ST_DIV:   if (cnt_last) state_d = alal_pkg::ST_SCALE;
      alal_pkg::ST_SCALE: state_d = wcorr_q ? alal_pkg::ST_MUL : alal_pkg::ST_DONE;
      alal_pkg::ST_MUL:   if (cnt_last) state_d = alal_pkg::ST_POST;
      alal_pkg::ST_POST:  state_d = post_done ? alal_pkg::ST_DONE : alal_pkg::ST_MUL;
      alal_pkg::ST_DONE:  if (out_free) state_d = alal_pkg::ST_IDLE;
      default:            state_d = alal_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = (state_q == alal_pkg::ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= alal_pkg::ST_IDLE;
      man_gain_q <= alal_pkg::GAIN_DEF;
      man_time_q <= alal_pkg::TIME_DEF;
      low_thr_q  <= alal_pkg::LOW_THR_DEF;
      high_thr_q <= alal_pkg::HIGH_THR_DEF;
      phase_q    <= alal_pkg::PH_IDLE;
      gain_q     <= alal_pkg::GAIN_DEF;
      tstep_q    <= alal_pkg::TIME_DEF;
      corr_q     <= 1'b0;
      cnt_q      <= '0;
      step_q     <= alal_pkg::STEP_A;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          alal_pkg::REG_MANUAL_GAIN: man_gain_q <= cfg_wdata_i[1:0];
          alal_pkg::REG_MANUAL_TIME: man_time_q <= cfg_wdata_i[2:0];
          alal_pkg::REG_LOW_THR:     low_thr_q  <= cfg_wdata_i;
          default:                   high_thr_q <= cfg_wdata_i;
        endcase
      end
      if (in_xfer && ctl.upd) begin
        phase_q <= ctl.phase;
        gain_q  <= ctl.gain;
        tstep_q <= ctl.tstep;
        corr_q  <= ctl.corr;
        cnt_q   <= CW'(NW);
      end else if (state_q == alal_pkg::ST_DIV || state_q == alal_pkg::ST_MUL) begin
        cnt_q <= cnt_q - CW'(1);
      end else if (state_q == alal_pkg::ST_SCALE || state_q == alal_pkg::ST_POST) begin
        cnt_q <= CW'(BW);
      end
      if (state_q == alal_pkg::ST_SCALE) begin
        step_q <= alal_pkg::STEP_A;
      end else if (state_q == alal_pkg::ST_POST) begin
        step_q <= alal_pkg::step_e'(step_q + 2'd1);
      end
      if (state_q == alal_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_xfer && ctl.upd) begin
      res_kind_q <= ctl.res_kind;
      res_gain_q <= ctl.res_gain;
      res_time_q <= ctl.res_time;
      res_corr_q <= ctl.res_corr;
      res_lux_q  <= 32'd0;
      wcorr_q    <= ctl.res_corr;
      n_q        <= num;
      rem_q      <= 12'd0;
    end
    case (state_q)
      alal_pkg::ST_DIV: begin
        n_q   <= {n_q[NW-2:0], dqb};
        rem_q <= rem_d;
      end
      alal_pkg::ST_SCALE: begin
        x10_q     <= x10;
        res_lux_q <= 32'(ux);
        p_q       <= PW'(xq);
        a_q       <= 64'(alal_pkg::COEF_A);
        neg_q     <= 1'b0;
      end
      alal_pkg::ST_MUL: begin
        p_q <= {msum, p_q[BW-1:1]};
      end
      alal_pkg::ST_POST: begin
        if (step_q == alal_pkg::STEP_D) begin
          res_lux_q <= luxf;
        end else if (post_done) begin
          res_lux_q <= 32'd0;
        end else begin
          a_q   <= hmag;
          neg_q <= hn[63];
          p_q   <= (step_q == alal_pkg::STEP_C) ? PW'(x10_q) : PW'(xq_hold);
        end
      end
      default: ;
    endcase
    if (state_q == alal_pkg::ST_DONE && out_free) begin
      out_kind_q <= res_kind_q;
      out_gain_q <= res_gain_q;
      out_time_q <= res_time_q;
      out_lux_q  <= res_lux_q;
      out_corr_q <= res_corr_q;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_kind_o          = out_kind_q;
  assign out_gain_index_o    = out_gain_q;
  assign out_time_index_o    = out_time_q;
  assign out_lux_x10_o       = out_lux_q;
  assign out_was_corrected_o = out_corr_q;

  a_nonlux_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o != alal_pkg::KIND_LUX |-> out_lux_x10_o == 32'd0
      && !out_was_corrected_o)
    else $error("non-lux result carries lux data");

  a_first_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == alal_pkg::ST_POST && step_q == alal_pkg::STEP_A |-> !neg_q)
    else $error("first Horner product negative");

  a_idle_err_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_cmd_i == alal_pkg::CMD_SAMPLE && phase_q == alal_pkg::PH_IDLE
      |=> state_q == alal_pkg::ST_DONE)
    else $error("idle sample did not go straight to output");

  a_mul_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == alal_pkg::ST_MUL || state_q == alal_pkg::ST_DIV |-> cnt_q != '0)
    else $error("serial counter ran out");

endmodule
